// ----- sv/modular_exponentiation_unit_macros.svh -----
// Assertion macros for the modular exponentiation unit.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MEU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MEU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/meu_pkg.sv -----
// Shared types and constants for the modular exponentiation unit.
// No dependencies; used by meu_seq and modular_exponentiation_unit.
`default_nettype none

package meu_pkg;

    // Fixed port widths of the transaction fields
    localparam int BASE_W = 63;
    localparam int EXPV_W = 64;
    localparam int MODV_W = 63;
    localparam int RES_W  = 63;

    // Datapath operations issued by the microcode
    typedef enum logic [3:0] {
        OP_NOP          = 4'd0,
        OP_LOAD         = 4'd1,
        OP_RED_STEP     = 4'd2,
        OP_SET_POWER    = 4'd3,
        OP_MUL_INIT_RES = 4'd4,
        OP_MUL_INIT_SQR = 4'd5,
        OP_MUL_STEP     = 4'd6,
        OP_WB_RES       = 4'd7,
        OP_WB_POW       = 4'd8,
        OP_PUT          = 4'd9,
        OP_CLR_RES      = 4'd10
    } t_op;

    // Datapath status seen by the sequencer's jump logic
    typedef struct packed {
        logic in_valid;
        logic mod_small;
        logic cnt_more;
        logic mul_more;
        logic exp_zero;
        logic exp_lsb;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// ----- sv/meu_seq.sv -----
// Microcode sequencer: step counter, program ROM and conditional jumps.
// Depends on meu_pkg for the operation codes and the status struct.
`default_nettype none

module meu_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire meu_pkg::t_status i_status,
    output meu_pkg::t_op         o_op
);
    import meu_pkg::*;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_INPUT  = 3'd2,
        C_MOD_SMALL = 3'd3,
        C_CNT_MORE  = 3'd4,
        C_MUL_MORE  = 3'd5,
        C_EXP_ZERO  = 3'd6,
        C_EXP_EVEN  = 3'd7
    } t_cond;

    typedef struct packed {
        t_op        op;
        t_cond      cond;
        logic [3:0] target;
    } t_uword;

    // Program addresses
    localparam logic [3:0] A_WAIT     = 4'd0;
    localparam logic [3:0] A_CHK_MOD  = 4'd1;
    localparam logic [3:0] A_RED      = 4'd2;
    localparam logic [3:0] A_SET_POW  = 4'd3;
    localparam logic [3:0] A_EXP_TEST = 4'd4;
    localparam logic [3:0] A_MI_RES   = 4'd5;
    localparam logic [3:0] A_MS_RES   = 4'd6;
    localparam logic [3:0] A_WB_RES   = 4'd7;
    localparam logic [3:0] A_MI_SQR   = 4'd8;
    localparam logic [3:0] A_MS_SQR   = 4'd9;
    localparam logic [3:0] A_WB_POW   = 4'd10;
    localparam logic [3:0] A_PUT      = 4'd11;
    localparam logic [3:0] A_RETURN   = 4'd12;
    localparam logic [3:0] A_ZERO     = 4'd13;

    logic [3:0] r_pc;
    logic [3:0] n_pc;
    t_uword     w_uw;
    logic       w_take;

    // Program ROM
    always_comb begin
        unique case (r_pc)
            A_WAIT:     w_uw = '{OP_LOAD,         C_NO_INPUT,  A_WAIT};
            A_CHK_MOD:  w_uw = '{OP_NOP,          C_MOD_SMALL, A_ZERO};
            A_RED:      w_uw = '{OP_RED_STEP,     C_CNT_MORE,  A_RED};
            A_SET_POW:  w_uw = '{OP_SET_POWER,    C_NEVER,     A_WAIT};
            A_EXP_TEST: w_uw = '{OP_NOP,          C_EXP_ZERO,  A_PUT};
            A_MI_RES:   w_uw = '{OP_MUL_INIT_RES, C_EXP_EVEN,  A_MI_SQR};
            A_MS_RES:   w_uw = '{OP_MUL_STEP,     C_MUL_MORE,  A_MS_RES};
            A_WB_RES:   w_uw = '{OP_WB_RES,       C_NEVER,     A_WAIT};
            A_MI_SQR:   w_uw = '{OP_MUL_INIT_SQR, C_NEVER,     A_WAIT};
            A_MS_SQR:   w_uw = '{OP_MUL_STEP,     C_MUL_MORE,  A_MS_SQR};
            A_WB_POW:   w_uw = '{OP_WB_POW,       C_ALWAYS,    A_EXP_TEST};
            A_PUT:      w_uw = '{OP_PUT,          C_ALWAYS,    A_PUT};
            A_RETURN:   w_uw = '{OP_NOP,          C_ALWAYS,    A_WAIT};
            A_ZERO:     w_uw = '{OP_CLR_RES,      C_ALWAYS,    A_PUT};
            default:    w_uw = '{OP_NOP,          C_ALWAYS,    A_WAIT};
        endcase
    end

    // Evaluate the jump condition
    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_INPUT:  w_take = !i_status.in_valid;
            C_MOD_SMALL: w_take = i_status.mod_small;
            C_CNT_MORE:  w_take = i_status.cnt_more;
            C_MUL_MORE:  w_take = i_status.mul_more;
            C_EXP_ZERO:  w_take = i_status.exp_zero;
            C_EXP_EVEN:  w_take = !i_status.exp_lsb;
            default:     w_take = 1'b0;
        endcase
    end

    // Hold on the put step until the output register frees up
    always_comb begin
        if (w_uw.op == OP_PUT) begin
            n_pc = i_status.out_busy ? A_PUT : A_RETURN;
        end else if (w_take) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = w_uw.op;

endmodule

`default_nettype wire

// ----- sv/modular_exponentiation_unit.sv -----
// Modular exponentiation unit: base^exponent mod modulus, one result per transaction.
// Works one transaction at a time. It first reduces the base bit by bit modulo the
// modulus, then per exponent bit runs up to two shift-and-add multiplies and a test step;
// scanning stops after the highest one bit of the exponent. The microcode sequencer
// steps the add/compare datapath through each of these steps.
// A modulus below 2 yields zero. The next transaction is taken while a result waits.
// Depends on meu_pkg, meu_seq and modular_exponentiation_unit_macros.svh.
`default_nettype none

`include "modular_exponentiation_unit_macros.svh"

module modular_exponentiation_unit #(
    parameter int EXP_BITS = 64,
    parameter int MOD_BITS = 63
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [meu_pkg::BASE_W-1:0] i_base_value,
    input  wire logic [meu_pkg::EXPV_W-1:0] i_exponent_value,
    input  wire logic [meu_pkg::MODV_W-1:0] i_modulus_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [meu_pkg::RES_W-1:0]       o_power_result
);
    import meu_pkg::*;

    localparam int CW = $clog2(MOD_BITS);

    // Fold a value below twice the modulus back under it
    function automatic logic [MOD_BITS-1:0] fold(input logic [MOD_BITS:0]   v,
                                                 input logic [MOD_BITS-1:0] m);
        logic [MOD_BITS:0] d;
        d = v - {1'b0, m};
        fold = (v >= {1'b0, m}) ? d[MOD_BITS-1:0] : v[MOD_BITS-1:0];
    endfunction

    logic [MOD_BITS-1:0] r_mod;
    logic [MOD_BITS-1:0] r_pow;
    logic [MOD_BITS-1:0] r_res;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_add;
    logic [MOD_BITS-1:0] r_y;
    logic [EXP_BITS-1:0] r_exp;
    logic [CW-1:0]       r_cnt;
    logic                r_out_valid;
    logic [MOD_BITS-1:0] r_out_data;

    t_op                 w_op;
    t_status             w_status;
    logic                w_accept;
    logic                w_put;
    logic                w_out_busy;
    logic [MOD_BITS-1:0] w_acc_sum;
    logic [MOD_BITS-1:0] w_add_dbl;
    logic [MOD_BITS-1:0] w_red;

    meu_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    // Handshake
    assign w_out_busy = r_out_valid && i_out_stall;
    assign o_in_stall = (w_op != OP_LOAD);
    assign w_accept   = i_in_valid && (w_op == OP_LOAD);
    assign w_put      = (w_op == OP_PUT) && !w_out_busy;

    // Status for the jump logic
    always_comb begin
        w_status.in_valid  = i_in_valid;
        w_status.mod_small = (r_mod[MOD_BITS-1:1] == '0);
        w_status.cnt_more  = (r_cnt != '0);
        w_status.mul_more  = (r_cnt != '0) && (r_y[MOD_BITS-1:1] != '0);
        w_status.exp_zero  = (r_exp == '0);
        w_status.exp_lsb   = r_exp[0];
        w_status.out_busy  = w_out_busy;
    end

    // Modular add, modular double and one reduction digit
    assign w_acc_sum = fold({1'b0, r_acc} + {1'b0, r_add}, r_mod);
    assign w_add_dbl = fold({r_add, 1'b0}, r_mod);
    assign w_red     = fold({r_acc, r_y[MOD_BITS-1]}, r_mod);

    // Datapath registers driven by the current control word
    always_ff @(posedge i_clk) begin
        case (w_op)
            OP_LOAD: begin
                if (w_accept) begin
                    r_y   <= i_base_value[MOD_BITS-1:0];
                    r_exp <= i_exponent_value[EXP_BITS-1:0];
                    r_mod <= i_modulus_value[MOD_BITS-1:0];
                    r_acc <= '0;
                    r_cnt <= CW'(MOD_BITS - 1);
                end
            end
            OP_RED_STEP: begin
                r_acc <= w_red;
                r_y   <= {r_y[MOD_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            OP_SET_POWER: begin
                r_pow <= r_acc;
                r_res <= MOD_BITS'(1);
            end
            OP_MUL_INIT_RES: begin
                r_acc <= '0;
                r_add <= r_res;
                r_y   <= r_pow;
                r_cnt <= CW'(MOD_BITS - 1);
            end
            OP_MUL_INIT_SQR: begin
                r_acc <= '0;
                r_add <= r_pow;
                r_y   <= r_pow;
                r_cnt <= CW'(MOD_BITS - 1);
            end
            OP_MUL_STEP: begin
                if (r_y[0]) begin
                    r_acc <= w_acc_sum;
                end
                r_add <= w_add_dbl;
                r_y   <= {1'b0, r_y[MOD_BITS-1:1]};
                r_cnt <= r_cnt - 1'b1;
            end
            OP_WB_RES: begin
                r_res <= r_acc;
            end
            OP_WB_POW: begin
                r_pow <= r_acc;
                r_exp <= {1'b0, r_exp[EXP_BITS-1:1]};
            end
            OP_CLR_RES: begin
                r_res <= '0;
            end
            default: begin
            end
        endcase
    end

    // Output register: load on put, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_put) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = RES_W'(r_out_data);

    // Checks
    `MEU_ASSERT_NEXT(a_busy_after_accept, w_accept, o_in_stall,
        "block took a second transaction right after accepting one")
    `MEU_ASSERT_NOW(a_mul_reduced, w_op == OP_MUL_STEP,
        (r_acc < r_mod) && (r_add < r_mod),
        "multiply operands left the reduced range")
    `MEU_ASSERT_NOW(a_result_reduced, w_put,
        (r_res < r_mod) || (r_mod[MOD_BITS-1:1] == '0),
        "result not fully reduced at output")

endmodule

`default_nettype wire

// ----- sim/modular_exponentiation_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for modular_exponentiation_unit: directed corners, then random phases.
// A scoreboard class predicts base^exponent mod modulus with wide products.
// Depends on meu_pkg and the modular_exponentiation_unit RTL.

class power_scoreboard;
    logic [meu_pkg::RES_W-1:0] expected_powers[$];
    int                        fail_count = 0;

    // Square-and-multiply with exact 128-bit products
    function logic [meu_pkg::RES_W-1:0] predict_power(
        logic [meu_pkg::BASE_W-1:0] base_v,
        logic [meu_pkg::EXPV_W-1:0] exp_v,
        logic [meu_pkg::MODV_W-1:0] mod_v
    );
        logic [127:0] wide_mod;
        logic [127:0] acc;
        logic [127:0] sqr;
        wide_mod = {65'd0, mod_v};
        if (mod_v < 2)
            return '0;
        acc = 128'd1;
        sqr = {65'd0, base_v} % wide_mod;
        for (int i = 0; i < meu_pkg::EXPV_W; i++) begin
            if (exp_v[i])
                acc = (acc * sqr) % wide_mod;
            sqr = (sqr * sqr) % wide_mod;
        end
        return acc[meu_pkg::RES_W-1:0];
    endfunction

    // Queue the expected residue of an accepted transaction
    function void note_operands(
        logic [meu_pkg::BASE_W-1:0] base_v,
        logic [meu_pkg::EXPV_W-1:0] exp_v,
        logic [meu_pkg::MODV_W-1:0] mod_v
    );
        expected_powers.push_back(predict_power(base_v, exp_v, mod_v));
    endfunction

    // Compare a delivered residue against the oldest expectation
    function void check_power(logic [meu_pkg::RES_W-1:0] got);
        logic [meu_pkg::RES_W-1:0] want;
        if (expected_powers.size() == 0) begin
            $display("%0t: unexpected power_result %0d, none pending", $time, got);
            fail_count++;
        end else begin
            want = expected_powers.pop_front();
            if (want !== got) begin
                $display("%0t: power_result expected %0d, actual %0d", $time, want, got);
                fail_count++;
            end
        end
    endfunction

    function int pending();
        return expected_powers.size();
    endfunction
endclass

module modular_exponentiation_unit_test;
    import meu_pkg::*;

    localparam logic [MODV_W-1:0] MOD_MAX      = {MODV_W{1'b1}};
    localparam logic [EXPV_W-1:0] EXP_ONES     = {EXPV_W{1'b1}};
    localparam int                DRAIN_CYCLES = 64 * (2 * 63 + 5) + 63 + 6 + 100;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [BASE_W-1:0] i_base_value = '0;
    logic [EXPV_W-1:0] i_exponent_value = '0;
    logic [MODV_W-1:0] i_modulus_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [RES_W-1:0]  o_power_result;

    power_scoreboard   sb = new();
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_left = 0;

    modular_exponentiation_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_base_value     (i_base_value),
        .i_exponent_value (i_exponent_value),
        .i_modulus_value  (i_modulus_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_power_result   (o_power_result)
    );

    always #2 i_clk = ~i_clk;

    // Drive output back-pressure: a long hold-off first, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every delivered result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_power(o_power_result);
    end

    // Offer one transaction after random idle cycles, hold it until accepted
    task automatic send_operands(
        logic [BASE_W-1:0] base_v,
        logic [EXPV_W-1:0] exp_v,
        logic [MODV_W-1:0] mod_v
    );
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_base_value     <= base_v;
        i_exponent_value <= exp_v;
        i_modulus_value  <= mod_v;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_operands(base_v, exp_v, mod_v);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Build one random transaction; most exponents are short to keep runs brief
    task automatic send_random(int exp_bits_max);
        logic [63:0]       r;
        logic [MODV_W-1:0] mod_v;
        logic [BASE_W-1:0] base_v;
        logic [EXPV_W-1:0] exp_v;
        int                pick;
        int                ebits;
        r    = {$urandom(), $urandom()};
        pick = $urandom_range(99);
        if (pick < 65)
            mod_v = (r[62:0] < 2) ? 63'd2 : r[62:0];
        else if (pick < 82)
            mod_v = MODV_W'($urandom_range(1000, 2));
        else if (pick < 97)
            mod_v = MOD_MAX - MODV_W'($urandom_range(15));
        else
            mod_v = MODV_W'($urandom_range(1));

        r    = {$urandom(), $urandom()};
        pick = $urandom_range(99);
        if (pick < 70)
            base_v = r[62:0];
        else if (pick < 80)
            base_v = '0;
        else if (pick < 90)
            base_v = mod_v - 63'd1;
        else
            base_v = BASE_W'($urandom_range(15));

        r     = {$urandom(), $urandom()};
        pick  = $urandom_range(99);
        ebits = (pick < 5) ? EXPV_W : $urandom_range(exp_bits_max, 1);
        exp_v = (ebits == EXPV_W) ? r : (r & ((64'd1 << ebits) - 1));
        if (pick >= 95)
            exp_v = '0;
        send_operands(base_v, exp_v, mod_v);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct, int exp_bits_max);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_random(exp_bits_max);
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: zero exponent, tiny and huge moduli, full-width exponents
        send_operands(63'd0, 64'd0, 63'd2);
        send_operands(63'd5, 64'd0, MOD_MAX);
        send_operands(63'd0, 64'd5, 63'd7);
        send_operands(MOD_MAX, 64'd1, MOD_MAX);
        send_operands(MOD_MAX, 64'd3, 63'd2);
        send_operands(MOD_MAX - 1, 64'd2, MOD_MAX);
        send_operands(MOD_MAX - 1, 64'd1, MOD_MAX);
        send_operands(63'd12345, EXP_ONES, MOD_MAX);
        send_operands(63'd3, EXP_ONES, 63'd1000000007);
        send_operands(63'd7, 64'd13, 63'd0);
        send_operands(63'd7, 64'd13, 63'd1);
        send_operands(MOD_MAX, EXP_ONES, 63'd0);
        send_operands(63'd2, 64'd62, MOD_MAX);
        send_operands(63'd2, 64'd63, MOD_MAX);
        send_operands(63'd1000, 64'd3, 63'd7);
        send_operands(63'd1, EXP_ONES, 63'd13);
        send_operands(MOD_MAX, 64'd2, 63'd3);
        send_operands(63'h2bad_cafe_1234_5678, 64'h8000_0000_0000_0000, MOD_MAX - 24);
        send_operands(63'd2, 64'h8000_0000_0000_0001, 63'h4000_0000_0000_0001);
        send_operands(63'd4, 64'd1, 63'h4000_0000_0000_0000);
        drain_results();

        // Random phases across idle and stall mixes
        run_phase(20, 0, 0, 16);
        run_phase(20, 87, 0, 16);
        run_phase(20, 0, 87, 16);
        run_phase(20, 38, 38, 16);

        // Hold the output off long enough for the unit to fill and stall its input
        hold_left = 20000;
        run_phase(12, 0, 0, 6);

        // Catch any stray result after the last expectation is met
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- modular_exponentiation_unit.f -----
+incdir+sv
sv/meu_pkg.sv
sv/meu_seq.sv
sv/modular_exponentiation_unit.sv
sim/modular_exponentiation_unit_test.sv
